FILE: hw/rtl/rspd_pkg.sv
// ----------------------------------------------------------------------------
// rspd_pkg: shared constants, types and helpers of the packet deframer.
// Holds the framing characters, the phase codes, the result kinds and the
// record that carries the outcome of decoding one received byte.
// ----------------------------------------------------------------------------
`default_nettype none

package rspd_pkg;

  // Framing characters of the serial protocol.
  localparam logic [7:0] START_MARK = 8'h24;  // '$'
  localparam logic [7:0] END_MARK   = 8'h23;  // '#'
  localparam logic [7:0] DIGIT_ZERO = 8'h30;  // '0'
  localparam logic [7:0] LETTER_A   = 8'h61;  // 'a'

  // Framing phase codes.
  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_CHECK1 = 2'd2;
  localparam logic [1:0] PH_CHECK2 = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  // One result request as it leaves the block.
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       send_ack;
    logic [7:0] packet_sum;
  } result_t;

  // Outcome of decoding one byte: the result, whether it exists, and the
  // next framing state.
  typedef struct packed {
    logic       emit;
    result_t    res;
    logic [1:0] phase_next;
    logic [7:0] sum_next;
    logic [7:0] first_next;
  } step_t;

  // Lowercase hex character for one nibble.
  function automatic logic [7:0] nibble_digit(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    if (nib < 4'd10) begin
      return DIGIT_ZERO + wide;
    end else begin
      return LETTER_A + wide - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rspd_decode.sv
// ----------------------------------------------------------------------------
// rspd_decode: framing decision for one received byte.
// Given the current framing state and a byte, works out the result request
// (if any) and the next state. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module rspd_decode (
  input  wire logic [1:0]     phase,
  input  wire logic [7:0]     running_sum,
  input  wire logic [7:0]     first_check_char,
  input  wire logic [7:0]     rx_byte,
  output rspd_pkg::step_t     step
);

  logic good;

  // Both check characters must match the sum as lowercase hex.
  assign good = (first_check_char == rspd_pkg::nibble_digit(running_sum[7:4])) &&
                (rx_byte == rspd_pkg::nibble_digit(running_sum[3:0]));

  // Phase-dependent decision.
  always_comb begin
    step                  = '0;
    step.phase_next       = phase;
    step.sum_next         = running_sum;
    step.first_next       = first_check_char;
    case (phase)
      rspd_pkg::PH_HUNT: begin
        if (rx_byte == rspd_pkg::START_MARK) begin
          step.sum_next   = 8'd0;
          step.phase_next = rspd_pkg::PH_DATA;
        end
      end
      rspd_pkg::PH_DATA: begin
        if (rx_byte == rspd_pkg::END_MARK) begin
          step.phase_next = rspd_pkg::PH_CHECK1;
        end else begin
          step.sum_next         = running_sum + rx_byte;
          step.emit             = 1'b1;
          step.res.kind         = rspd_pkg::KIND_PAYLOAD;
          step.res.payload_byte = rx_byte;
        end
      end
      rspd_pkg::PH_CHECK1: begin
        step.first_next = rx_byte;
        step.phase_next = rspd_pkg::PH_CHECK2;
      end
      rspd_pkg::PH_CHECK2: begin
        step.emit           = 1'b1;
        step.res.kind       = good ? rspd_pkg::KIND_GOOD : rspd_pkg::KIND_BAD;
        step.res.send_ack   = good;
        step.res.packet_sum = running_sum;
        step.phase_next     = rspd_pkg::PH_HUNT;
      end
      default: begin
        step.phase_next = rspd_pkg::PH_HUNT;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rsp_packet_deframer.sv
// ----------------------------------------------------------------------------
// rsp_packet_deframer: remote serial protocol packet deframer.
// Frames '$' payload '#' h1 h2 packets, streams payload bytes out and checks
// the two-digit lowercase hex checksum.
// ----------------------------------------------------------------------------
// Each received byte is one input request; the block takes one per clock
// cycle while in_stall is low. A byte waits in the input register, is decoded
// against the framing state, and its result (if any) lands in the output
// register and is offered at the outputs from there.
// Hunting bytes, the end mark and the first check digit produce no result.
// Input stall is raised only when a byte that produces a result is waiting in
// the input register and the output register is still held by the downstream
// side. There is no reset-time clearing pass; the block is ready right after
// reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_packet_deframer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      kind,
  output logic [7:0]      payload_byte,
  output logic            send_ack,
  output logic [7:0]      packet_sum
);

  logic                 hold_valid;
  logic [7:0]           hold_byte;
  logic [1:0]           phase;
  logic [7:0]           running_sum;
  logic [7:0]           first_check_char;
  rspd_pkg::step_t      step;
  rspd_pkg::result_t    result;
  logic                 out_free;
  logic                 advance;

  // Decode the held byte against the framing state.
  rspd_decode u_decode (
    .phase            (phase),
    .running_sum      (running_sum),
    .first_check_char (first_check_char),
    .rx_byte          (hold_byte),
    .step             (step)
  );

  // The held byte moves on unless its result has nowhere to go.
  assign out_free = !out_valid || !out_stall;
  assign advance  = hold_valid && (!step.emit || out_free);
  assign in_stall = hold_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      hold_byte <= rx_byte;
    end
  end

  // Framing state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= rspd_pkg::PH_HUNT;
      running_sum      <= 8'd0;
      first_check_char <= 8'd0;
    end else if (advance) begin
      phase            <= step.phase_next;
      running_sum      <= step.sum_next;
      first_check_char <= step.first_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && step.emit;
    end
    if (advance && step.emit) begin
      result <= step.res;
    end
  end

  assign kind         = result.kind;
  assign payload_byte = result.payload_byte;
  assign send_ack     = result.send_ack;
  assign packet_sum   = result.packet_sum;

endmodule

`default_nettype wire

FILE: dv/rsp_packet_deframer_tb.sv
// ----------------------------------------------------------------------------
// rsp_packet_deframer_tb: self-checking testbench of the packet deframer.
// Feeds received bytes through the valid/stall input channel, predicts every
// payload, good-end and bad-end result with a behavioral frame tracker, and
// checks each result in order as it leaves the block. Directed frames come
// first, then a long back-pressure stretch, then random traffic under several
// idle and stall mixes.
// ----------------------------------------------------------------------------
module rsp_packet_deframer_tb;

  // Ways of writing the two check digits after the end mark.
  localparam logic [1:0] CHK_GOOD  = 2'd0;
  localparam logic [1:0] CHK_UPPER = 2'd1;
  localparam logic [1:0] CHK_WRONG = 2'd2;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 150;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic       send_ack;
  logic [7:0] packet_sum;

  // Frame tracker state and the results it still waits for.
  logic [1:0]        fr_phase;
  logic [7:0]        fr_sum;
  logic [7:0]        fr_first;
  rspd_pkg::result_t results_due[$];

  int errors;
  int cycles;
  int bytes_framed;
  int send_pct;
  int stall_pct;
  int hold_requests;
  int holds_begun;
  int hold_left;

  rsp_packet_deframer dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .send_ack     (send_ack),
    .packet_sum   (packet_sum)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hex character of one nibble, lowercase unless asked otherwise.
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic upper);
    logic [7:0] base;
    base = upper ? rspd_pkg::LETTER_A - 8'h20 : rspd_pkg::LETTER_A;
    if (nib < 4'd10) begin
      return rspd_pkg::DIGIT_ZERO + {4'b0000, nib};
    end else begin
      return base + {4'b0000, nib} - 8'd10;
    end
  endfunction

  // Track the framing of one accepted byte and queue the result it causes.
  function automatic void predict_frame(input logic [7:0] b);
    rspd_pkg::result_t r;
    logic              good;
    r = '0;
    case (fr_phase)
      rspd_pkg::PH_HUNT: begin
        if (b == rspd_pkg::START_MARK) begin
          fr_sum   = 8'd0;
          fr_phase = rspd_pkg::PH_DATA;
        end
      end
      rspd_pkg::PH_DATA: begin
        if (b == rspd_pkg::END_MARK) begin
          fr_phase = rspd_pkg::PH_CHECK1;
        end else begin
          fr_sum         = fr_sum + b;
          r.kind         = rspd_pkg::KIND_PAYLOAD;
          r.payload_byte = b;
          results_due.push_back(r);
        end
      end
      rspd_pkg::PH_CHECK1: begin
        fr_first = b;
        fr_phase = rspd_pkg::PH_CHECK2;
      end
      default: begin
        good = (fr_first == hex_char(fr_sum[7:4], 1'b0)) &&
               (b == hex_char(fr_sum[3:0], 1'b0));
        r.kind       = good ? rspd_pkg::KIND_GOOD : rspd_pkg::KIND_BAD;
        r.send_ack   = good;
        r.packet_sum = fr_sum;
        results_due.push_back(r);
        fr_phase = rspd_pkg::PH_HUNT;
      end
    endcase
  endfunction

  // Offer one byte, idling first at random, and hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    if (fr_phase != rspd_pkg::PH_HUNT || b == rspd_pkg::START_MARK) begin
      bytes_framed++;
    end
    predict_frame(b);
  endtask

  // Send the two check digits for a given sum.
  task automatic send_check(input logic [7:0] sum, input logic [1:0] mode);
    logic [7:0] hi;
    logic [7:0] lo;
    case (mode)
      CHK_GOOD: begin
        hi = hex_char(sum[7:4], 1'b0);
        lo = hex_char(sum[3:0], 1'b0);
      end
      CHK_UPPER: begin
        hi = hex_char(sum[7:4], 1'b1);
        lo = hex_char(sum[3:0], 1'b1);
      end
      default: begin
        // Each digit is good or a random byte at even odds; both may be good or both random.
        hi = $urandom_range(1) ? hex_char(sum[7:4], 1'b0) : 8'($urandom_range(255));
        lo = $urandom_range(1) ? 8'($urandom_range(255)) : hex_char(sum[3:0], 1'b0);
      end
    endcase
    send_byte(hi);
    send_byte(lo);
  endtask

  // Send a whole frame with random payload bytes.
  task automatic send_random_packet(input int len, input logic [1:0] mode);
    logic [7:0] b;
    logic [7:0] sum;
    int         i;
    sum = 8'd0;
    send_byte(rspd_pkg::START_MARK);
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (b == rspd_pkg::END_MARK) begin
        b = rspd_pkg::START_MARK;
      end
      sum = sum + b;
      send_byte(b);
    end
    send_byte(rspd_pkg::END_MARK);
    send_check(sum, mode);
  endtask

  // Stop offering bytes and wait until every predicted result has arrived.
  task automatic wait_drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Directed frames: noise while hunting, empty payload, start mark inside
  // a payload, uppercase digits and a wrong checksum.
  task automatic test_directed;
    send_pct  = 0;
    stall_pct = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(rspd_pkg::END_MARK);
    send_byte(rspd_pkg::LETTER_A);
    send_byte(rspd_pkg::START_MARK);
    send_byte(rspd_pkg::END_MARK);
    send_check(8'h00, CHK_GOOD);
    send_byte(rspd_pkg::START_MARK);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(rspd_pkg::START_MARK);
    send_byte(rspd_pkg::END_MARK);
    send_check(8'h23, CHK_GOOD);
    send_byte(rspd_pkg::START_MARK);
    send_byte(8'hAB);
    send_byte(rspd_pkg::END_MARK);
    send_check(8'hAB, CHK_UPPER);
    send_byte(rspd_pkg::START_MARK);
    send_byte(8'h01);
    send_byte(rspd_pkg::END_MARK);
    send_byte(rspd_pkg::DIGIT_ZERO);
    send_byte(rspd_pkg::DIGIT_ZERO + 8'd2);
    wait_drain;
  endtask

  // The receiver holds off for a long stretch while a long frame streams in.
  task automatic test_backpressure;
    send_pct  = 0;
    stall_pct = 0;
    hold_requests++;
    send_random_packet(60, CHK_GOOD);
    wait_drain;
  endtask

  // Random traffic: mostly well-formed frames, some noise and broken frames.
  task automatic test_random_traffic(input int target, input int s_pct, input int r_pct);
    int         start;
    int         pick;
    int         len;
    int         n;
    logic [1:0] mode;
    send_pct  = s_pct;
    stall_pct = r_pct;
    start     = bytes_framed;
    while (bytes_framed - start < target) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        len  = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(40, 9);
        pick = $urandom_range(99);
        mode = (pick < 70) ? CHK_GOOD : (pick < 85) ? CHK_UPPER : CHK_WRONG;
        send_random_packet(len, mode);
      end else begin
        // Noise that can open, cut or close a frame at any point.
        n = $urandom_range(6, 1);
        repeat (n) begin
          pick = $urandom_range(99);
          send_byte(pick < 15 ? rspd_pkg::START_MARK :
                    pick < 30 ? rspd_pkg::END_MARK : 8'($urandom_range(255)));
        end
      end
    end
    wait_drain;
  endtask

  // Receiver stall: random by percentage, or a long counted hold-off.
  always @(posedge clk) begin
    if (hold_requests != holds_begun) begin
      holds_begun++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    rspd_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result kind=%0d byte=%h ack=%b sum=%h",
                 $time, kind, payload_byte, send_ack, packet_sum);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
          errors++;
        end
        if (payload_byte !== want.payload_byte) begin
          $display("%0t: payload_byte expected %h actual %h",
                   $time, want.payload_byte, payload_byte);
          errors++;
        end
        if (send_ack !== want.send_ack) begin
          $display("%0t: send_ack expected %b actual %b", $time, want.send_ack, send_ack);
          errors++;
        end
        if (packet_sum !== want.packet_sum) begin
          $display("%0t: packet_sum expected %h actual %h",
                   $time, want.packet_sum, packet_sum);
          errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    errors        = 0;
    cycles        = 0;
    bytes_framed  = 0;
    send_pct      = 0;
    stall_pct     = 0;
    hold_requests = 0;
    holds_begun   = 0;
    hold_left     = 0;
    fr_phase      = rspd_pkg::PH_HUNT;
    fr_sum        = 8'd0;
    fr_first      = 8'd0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= 8'd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed;
    test_backpressure;
    test_random_traffic(475, 0, 0);
    test_random_traffic(475, 54, 0);
    test_random_traffic(475, 0, 54);
    test_random_traffic(475, 35, 35);

    repeat (8) @(posedge clk);
    if (errors == 0 && results_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: rsp_packet_deframer.f
hw/rtl/rspd_pkg.sv
hw/rtl/rspd_decode.sv
hw/rtl/rsp_packet_deframer.sv
dv/rsp_packet_deframer_tb.sv
